// File: design/msb_bit_reader_octal_int_macros.svh
// Assertion macros for the MSB-first bit reader.
// Included by the top level; no other dependencies.
`ifndef MSB_BIT_READER_OCTAL_INT_MACROS_SVH
`define MSB_BIT_READER_OCTAL_INT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MSBR_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msbr: assertion failed");
// next-cycle implication
`define MSBR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msbr: assertion failed");
`else
`define MSBR_ASSERT_IMPL(name, clk, rst, ante, cons)
`define MSBR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: design/msbr_pkg.sv
// Shared types and constants for the MSB-first bit reader.
// No dependencies.
package msbr_pkg;

  // default ring size and read-width cap
  localparam int BufferBytesDefault = 16;
  localparam int MaxReadBits        = 32;

  // command codes
  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_READ_BITS = 3'd1;
  localparam logic [2:0] CMD_READ_INT  = 3'd2;
  localparam logic [2:0] CMD_ALIGN     = 3'd3;
  localparam logic [2:0] CMD_MARK_END  = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SHORT    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // input item
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [5:0] bit_count;
  } item_t;

  // result item
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic        at_end;
  } result_t;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK
  } state_t;

  // sequencer to bit fetch unit
  typedef struct packed {
    logic restart;
    logic run;
  } fetch_ctl_t;

  // bit fetch unit to sequencer
  typedef struct packed {
    logic vld;
    logic val;
  } fetch_bit_t;

  // sequencer to accumulator
  typedef struct packed {
    logic clr;
    logic shift;
    logic din;
  } acc_ctl_t;

endpackage

// File: design/msbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/msbr_bit_fetch.sv
// Bit fetch unit: walks the stream one bit per cycle from the byte ring.
// Depends on msbr_pkg; drives the read port of msbr_ram.
module msbr_bit_fetch #(
  parameter int BUFFER_BYTES = msbr_pkg::BufferBytesDefault,
  localparam int HW  = $clog2(BUFFER_BYTES),
  localparam int FW  = $clog2(BUFFER_BYTES + 1),
  localparam int AVW = FW + 3,
  localparam int KW  = $clog2(8 * BUFFER_BYTES + 64)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  msbr_pkg::fetch_ctl_t ctl,
  input  logic [KW-1:0]        limit,
  input  logic [HW-1:0]        head,
  input  logic [2:0]           off,
  input  logic [AVW-1:0]       avail,
  output logic [HW-1:0]        raddr,
  input  logic [7:0]           rdata,
  output msbr_pkg::fetch_bit_t fbit
);

  localparam int HW1 = HW + 1;
  localparam logic [HW:0] Depth = BUFFER_BYTES[HW:0];

  logic [KW-1:0] k;
  logic          issue;
  logic          past;
  logic [KW-1:0] abs_pos;
  logic [HW:0]   slot_sum;
  logic          vld_q;
  logic          past_q;
  logic [2:0]    sub_q;

  // issue stage: address of bit k ahead of the read position
  always_comb begin
    issue    = ctl.run && (k < limit);
    past     = (k >= KW'(avail));
    abs_pos  = KW'(off) + k;
    slot_sum = HW1'(head) + HW1'(abs_pos >> 3);
    raddr    = (slot_sum >= Depth) ? HW'(slot_sum - Depth) : HW'(slot_sum);
  end

  // bit counter and issue valid
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctl.restart) begin
        k <= '0;
      end else if (issue) begin
        k <= k + KW'(1);
      end
      vld_q <= issue && !ctl.restart;
    end
  end

  // bit position travels with the read
  always_ff @(posedge clk) begin
    past_q <= past;
    sub_q  <= abs_pos[2:0];
  end

  // data stage: past the buffered data every bit is a one
  always_comb begin
    fbit.vld = vld_q;
    fbit.val = past_q | rdata[3'd7 - sub_q];
  end

endmodule

// File: design/msbr_shift_acc.sv
// Serial value accumulator: shifts one bit in per cycle while shift is set, tracks overflow.
// Depends on msbr_pkg.
module msbr_shift_acc (
  input  logic               clk,
  input  logic               rst,
  input  msbr_pkg::acc_ctl_t ctl,
  output logic [63:0]        acc,
  output logic               ovf
);

  // a one shifted out of the top means the value needs more than 64 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (ctl.clr) begin
      ovf <= 1'b0;
    end else if (ctl.shift) begin
      ovf <= ovf | acc[63];
    end
  end

  // value shift register
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= {acc[62:0], ctl.din};
    end
  end

endmodule

// File: design/msb_bit_reader_octal_int.sv
// Top level of the MSB-first bit reader over a byte ring buffer.
// Depends on msbr_pkg, msbr_ram, msbr_bit_fetch, msbr_shift_acc and the macro header.
`include "msb_bit_reader_octal_int_macros.svh"

// Each accepted item gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall it, so capture it then. Bits leave the ring
// one per cycle through the single RAM read port during a read. Push, align,
// mark end, unknown commands, zero-count and failed bit reads finish in the
// dispatch state; bit and integer reads then walk the ring bit by bit (a short
// integer read stops at the first group that runs past the data). busy is low
// while done is high, so the next item can be taken in the result cycle.
module msb_bit_reader_octal_int #(
  parameter int BUFFER_BYTES = msbr_pkg::BufferBytesDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  msbr_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output msbr_pkg::result_t result
);

  localparam int HW  = $clog2(BUFFER_BYTES);
  localparam int HW1 = HW + 1;
  localparam int FW  = $clog2(BUFFER_BYTES + 1);
  localparam int AVW = FW + 3;
  localparam int KW  = $clog2(8 * BUFFER_BYTES + 64);
  localparam logic [HW:0]   Depth     = BUFFER_BYTES[HW:0];
  localparam logic [FW-1:0] DepthFill = BUFFER_BYTES[FW-1:0];

  msbr_pkg::state_t     state, state_next;
  logic [HW-1:0]        head, head_next;
  logic [FW-1:0]        fill, fill_next;
  logic [2:0]           off, off_next;
  logic                 end_marked, end_next;
  logic [KW-1:0]        rcnt, rcnt_next;
  logic                 term_q, term_next;
  logic                 done_next;
  msbr_pkg::result_t    res_next;

  logic [2:0]           cmd_q;
  logic [7:0]           data_q;
  logic [5:0]           cnt_q;

  logic [AVW-1:0]       avail;
  logic                 bits_short;
  logic                 walk_done;
  logic [KW-1:0]        rcnt1;
  logic [KW-1:0]        cons_k;
  logic                 cons_all;
  logic [KW-1:0]        cons_total;
  logic [HW:0]          cons_whole;
  logic [63:0]          shifted;
  logic                 ovf_now;

  logic                 ram_we;
  logic [HW-1:0]        ram_waddr;
  logic [HW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  logic [KW-1:0]        limit;
  msbr_pkg::fetch_ctl_t fctl;
  msbr_pkg::fetch_bit_t fbit;
  msbr_pkg::acc_ctl_t   actl;
  logic [63:0]          acc;
  logic                 acc_ovf;

  // ring index add with one wrap; x never exceeds the ring size
  function automatic logic [HW-1:0] ring_add(input logic [HW-1:0] h, input logic [HW:0] x);
    logic [HW:0] s;
    s = HW1'(h) + x;
    return (s >= Depth) ? HW'(s - Depth) : HW'(s);
  endfunction

  assign busy = (state != msbr_pkg::S_IDLE);

  // buffered bits ahead of the read position
  always_comb begin
    avail      = (fill == '0) ? '0 : ({fill, 3'b000} - AVW'(off));
    bits_short = !end_marked && (KW'(cnt_q) > KW'(avail));
    rcnt1      = rcnt + KW'(1);
    shifted    = {acc[62:0], fbit.val};
    ovf_now    = acc_ovf | acc[63];
    limit      = (cmd_q == msbr_pkg::CMD_READ_BITS) ? KW'(cnt_q) : '1;
    ram_waddr  = ring_add(head, HW1'(fill));
  end

  // consume arithmetic for a finished read
  always_comb begin
    cons_k     = (cmd_q == msbr_pkg::CMD_READ_BITS) ? KW'(cnt_q) : rcnt1;
    cons_all   = (cons_k >= KW'(avail));
    cons_total = KW'(off) + cons_k;
    cons_whole = HW1'(cons_total >> 3);
  end

  // walk completion: last bit of a bit read, or end of a group that settles an integer
  always_comb begin
    walk_done = 1'b0;
    if (state == msbr_pkg::S_WALK && fbit.vld) begin
      if (cmd_q == msbr_pkg::CMD_READ_BITS) begin
        walk_done = (rcnt1 == KW'(cnt_q));
      end else if (rcnt[1:0] == 2'b11) begin
        walk_done = term_q || (!end_marked && (rcnt1 > KW'(avail)));
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      msbr_pkg::S_IDLE: begin
        if (start) begin
          state_next = msbr_pkg::S_DISPATCH;
        end
      end
      msbr_pkg::S_DISPATCH: begin
        if (cmd_q == msbr_pkg::CMD_READ_INT) begin
          state_next = msbr_pkg::S_WALK;
        end else if (cmd_q == msbr_pkg::CMD_READ_BITS && cnt_q != '0 && !bits_short) begin
          state_next = msbr_pkg::S_WALK;
        end else begin
          state_next = msbr_pkg::S_IDLE;
        end
      end
      msbr_pkg::S_WALK: begin
        if (walk_done) begin
          state_next = msbr_pkg::S_IDLE;
        end
      end
      default: state_next = msbr_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    head_next  = head;
    fill_next  = fill;
    off_next   = off;
    end_next   = end_marked;
    rcnt_next  = rcnt;
    term_next  = term_q;
    done_next  = 1'b0;
    res_next   = result;
    ram_we     = 1'b0;
    fctl       = '0;
    actl       = '0;
    actl.din   = fbit.val;

    case (state)
      msbr_pkg::S_DISPATCH: begin
        rcnt_next = '0;
        term_next = 1'b0;
        done_next = 1'b1;
        res_next.value  = '0;
        res_next.status = msbr_pkg::STAT_OK;
        case (cmd_q)
          msbr_pkg::CMD_PUSH: begin
            if (fill == DepthFill) begin
              res_next.status = msbr_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              fill_next = fill + FW'(1);
            end
          end
          msbr_pkg::CMD_READ_BITS: begin
            if (cnt_q != '0) begin
              if (bits_short) begin
                res_next.status = msbr_pkg::STAT_SHORT;
              end else begin
                done_next    = 1'b0;
                fctl.restart = 1'b1;
                actl.clr     = 1'b1;
              end
            end
          end
          msbr_pkg::CMD_READ_INT: begin
            done_next    = 1'b0;
            fctl.restart = 1'b1;
            actl.clr     = 1'b1;
          end
          msbr_pkg::CMD_ALIGN: begin
            // a partly read byte is dropped whole
            if (off != '0) begin
              head_next = ring_add(head, HW1'(1));
              fill_next = fill - FW'(1);
              off_next  = '0;
            end
          end
          msbr_pkg::CMD_MARK_END: begin
            end_next = 1'b1;
          end
          default: begin
          end
        endcase
      end

      msbr_pkg::S_WALK: begin
        fctl.run = 1'b1;
        if (fbit.vld) begin
          rcnt_next = rcnt1;
          if (cmd_q == msbr_pkg::CMD_READ_BITS) begin
            actl.shift = 1'b1;
          end else if (rcnt[1:0] == 2'b00) begin
            // first bit of a group marks the last group
            term_next = fbit.val;
          end else begin
            actl.shift = 1'b1;
          end
        end

        if (walk_done) begin
          done_next       = 1'b1;
          res_next.value  = '0;
          res_next.status = msbr_pkg::STAT_OK;
          // a group that runs past the data fails the read, even a last group
          if (cmd_q == msbr_pkg::CMD_READ_INT && !end_marked && (rcnt1 > KW'(avail))) begin
            res_next.status = msbr_pkg::STAT_SHORT;
          end else begin
            if (cmd_q == msbr_pkg::CMD_READ_INT && ovf_now) begin
              res_next.value  = '1;
              res_next.status = msbr_pkg::STAT_OVERFLOW;
            end else begin
              res_next.value = shifted;
            end
            // consume the bits read
            if (cons_all) begin
              head_next = ring_add(head, HW1'(fill));
              fill_next = '0;
              off_next  = '0;
            end else begin
              head_next = ring_add(head, cons_whole);
              fill_next = fill - FW'(cons_whole);
              off_next  = cons_total[2:0];
            end
          end
        end
      end

      default: begin
      end
    endcase

    res_next.at_end = done_next ? (end_next && fill_next == '0) : result.at_end;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= msbr_pkg::S_IDLE;
      head       <= '0;
      fill       <= '0;
      off        <= '0;
      end_marked <= 1'b0;
      rcnt       <= '0;
      term_q     <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      fill       <= fill_next;
      off        <= off_next;
      end_marked <= end_next;
      rcnt       <= rcnt_next;
      term_q     <= term_next;
      done       <= done_next;
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q  <= item.cmd;
      data_q <= item.data_byte;
      cnt_q  <= (item.bit_count > 6'(msbr_pkg::MaxReadBits)) ?
                6'(msbr_pkg::MaxReadBits) : item.bit_count;
    end
    result <= res_next;
  end

  // byte ring
  msbr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one bit per cycle from the ring
  msbr_bit_fetch #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_fetch (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fctl),
    .limit (limit),
    .head  (head),
    .off   (off),
    .avail (avail),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .fbit  (fbit)
  );

  // serial value accumulator
  msbr_shift_acc u_acc (
    .clk (clk),
    .rst (rst),
    .ctl (actl),
    .acc (acc),
    .ovf (acc_ovf)
  );

  // checks
  `MSBR_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill <= DepthFill)
  `MSBR_ASSERT_IMPL(a_empty_aligned, clk, rst, fill == '0, off == '0)
  `MSBR_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `MSBR_ASSERT_IMPL(a_short_keeps, clk, rst, done && result.status == msbr_pkg::STAT_SHORT, head == $past(head) && fill == $past(fill) && off == $past(off))

endmodule

// File: tb/sv/tb_msb_bit_reader_octal_int.sv
// Self-checking testbench for msb_bit_reader_octal_int, the MSB-first bit reader.
// Depends on msbr_pkg and the reader RTL; a built-in bit stream model predicts each result.
`timescale 1ns / 1ps

module tb_msb_bit_reader_octal_int;
  import msbr_pkg::*;

  localparam int RingBytes = BufferBytesDefault;
  localparam int StallLimit = 1000;
  localparam int TailCycles = 20;
  localparam int OpenPhaseItems = 950;
  localparam int ClosedPhaseItems = 950;

  // command codes the reader ignores
  localparam logic [2:0] CmdUnusedLo = 3'd5;
  localparam logic [2:0] CmdUnusedHi = 3'd7;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  logic    done;
  item_t   item_in;
  result_t result_out;

  // expected results, oldest first
  result_t expected_results[$];
  int      mismatches;
  int      items_sent;
  int      gap_style;
  int      stall_cycles;

  // bit stream model state
  logic [7:0]  ring_bytes[RingBytes];
  int unsigned ring_head;
  int unsigned ring_fill;
  int unsigned ring_boff;
  bit          stream_closed;

  msb_bit_reader_octal_int i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item_in),
    .busy   (busy),
    .done   (done),
    .result (result_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- bit stream model ----------------

  function automatic int unsigned bits_buffered();
    return (ring_fill == 0) ? 0 : ring_fill * 8 - ring_boff;
  endfunction

  // bit k ahead of the read point; ones past the buffered data
  function automatic logic stream_bit(int unsigned k);
    int unsigned pos;
    if (k >= bits_buffered()) return 1'b1;
    pos = ring_boff + k;
    return ring_bytes[(ring_head + pos / 8) % RingBytes][7 - (pos % 8)];
  endfunction

  function automatic logic [63:0] stream_bits(int unsigned first, int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++) v = {v[62:0], stream_bit(first + i)};
    return v;
  endfunction

  function automatic void drop_bits(int unsigned k);
    int unsigned total;
    if (k >= bits_buffered()) begin
      ring_head = (ring_head + ring_fill) % RingBytes;
      ring_fill = 0;
      ring_boff = 0;
      return;
    end
    total = ring_boff + k;
    ring_head = (ring_head + total / 8) % RingBytes;
    ring_fill -= total / 8;
    ring_boff = total % 8;
  endfunction

  // applies one item to the model and returns the result it gives
  function automatic result_t reader_step(item_t it);
    result_t     r;
    int unsigned cnt;
    int unsigned pos;
    logic [63:0] acc;
    logic [3:0]  grp;
    bit          ovf;
    bit          short_read;
    r = '0;
    r.status = STAT_OK;
    case (it.cmd)
      CMD_PUSH: begin
        if (ring_fill >= RingBytes) r.status = STAT_FULL;
        else begin
          ring_bytes[(ring_head + ring_fill) % RingBytes] = it.data_byte;
          ring_fill++;
        end
      end
      CMD_READ_BITS: begin
        cnt = (it.bit_count > MaxReadBits) ? MaxReadBits : it.bit_count;
        if (!stream_closed && cnt > bits_buffered()) r.status = STAT_SHORT;
        else begin
          r.value = stream_bits(0, cnt);
          drop_bits(cnt);
        end
      end
      CMD_READ_INT: begin
        pos = 0;
        acc = '0;
        ovf = 1'b0;
        short_read = 1'b0;
        // walk 4-bit groups until one has its top bit set or the buffered data runs short
        while (1'b1) begin
          if (!stream_closed && pos + 4 > bits_buffered()) begin
            short_read = 1'b1;
            break;
          end
          grp = 4'(stream_bits(pos, 4));
          pos += 4;
          if (acc[63:61] != 3'd0) ovf = 1'b1;
          acc = {acc[60:0], grp[2:0]};
          if (grp[3]) break;
        end
        if (short_read) r.status = STAT_SHORT;
        else begin
          drop_bits(pos);
          if (ovf) begin
            r.value = '1;
            r.status = STAT_OVERFLOW;
          end else begin
            r.value = acc;
          end
        end
      end
      CMD_ALIGN: begin
        if (ring_boff != 0) drop_bits(8 - ring_boff);
      end
      CMD_MARK_END: stream_closed = 1'b1;
      default: ;
    endcase
    r.at_end = stream_closed && (ring_fill == 0);
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", result_out.value, '0);
      end else begin
        want = expected_results.pop_front();
        if (result_out.value !== want.value)
          note_mismatch("value", result_out.value, want.value);
        if (result_out.status !== want.status)
          note_mismatch("status", 64'(result_out.status), 64'(want.status));
        if (result_out.at_end !== want.at_end)
          note_mismatch("at_end", 64'(result_out.at_end), 64'(want.at_end));
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("tb_msb_bit_reader_octal_int NOT OK");
      $finish;
    end
  end

  // ---------------- driving ----------------

  function automatic int idle_draw();
    case (gap_style)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  // sends one item; returns at the edge that accepts it
  task automatic send_item(input logic [2:0] c, input logic [7:0] d, input logic [5:0] n);
    item_t it;
    int    gap;
    it.cmd = c;
    it.data_byte = d;
    it.bit_count = n;
    gap = idle_draw();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_results.push_back(reader_step(it));
    start <= 1'b1;
    item_in <= it;
    items_sent++;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // holds off new items until every result has come back
  task automatic wait_reader_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic push_random();
    send_item(CMD_PUSH, 8'($urandom), 6'($urandom));
  endtask

  // integer encoded as 4-bit groups, then read back
  task automatic seq_integer();
    int         groups;
    logic [3:0] nibs[$];
    groups = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 26) : $urandom_range(1, 8);
    for (int i = 0; i < groups; i++) nibs.push_back({i == groups - 1, 3'($urandom)});
    // a leading zero group keeps the value and pads to whole bytes
    if (groups % 2 != 0) nibs.push_front(4'h0);
    for (int i = 0; i < nibs.size(); i += 2)
      send_item(CMD_PUSH, {nibs[i], nibs[i + 1]}, 6'($urandom));
    send_item(CMD_READ_INT, 8'($urandom), 6'($urandom));
    if ($urandom_range(0, 3) == 0) send_item(CMD_ALIGN, 8'($urandom), 6'($urandom));
  endtask

  // a few bytes read back as bit fields of random widths
  task automatic seq_fields();
    logic [5:0] cnt;
    repeat ($urandom_range(1, 6)) push_random();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0: cnt = 6'd0;
        1: cnt = 6'($urandom_range(33, 63));
        default: cnt = 6'($urandom_range(1, 32));
      endcase
      send_item(CMD_READ_BITS, 8'($urandom), cnt);
      if ($urandom_range(0, 5) == 0) send_item(CMD_ALIGN, 8'($urandom), 6'($urandom));
    end
  endtask

  // one item with every field random; mark end turns into align while the stream is open
  task automatic seq_noise();
    logic [2:0] c;
    c = 3'($urandom);
    if (c == CMD_MARK_END && !stream_closed) c = CMD_ALIGN;
    send_item(c, 8'($urandom), 6'($urandom));
  endtask

  task automatic run_random(input int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      gap_style = $urandom_range(0, 2);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: seq_integer();
        7, 8, 9, 10, 11, 12: seq_fields();
        13, 14, 15, 16, 17: seq_noise();
        default: repeat ($urandom_range(8, 20)) push_random();
      endcase
      if ($urandom_range(0, 24) == 0) wait_reader_idle();
    end
  endtask

  // ---------------- tests ----------------

  // reads and no-op commands on an empty ring
  task automatic test_empty_reader();
    gap_style = 0;
    send_item(CMD_READ_BITS, 8'h00, 6'h3f);
    send_item(CMD_READ_INT, 8'hff, 6'h00);
    send_item(CMD_ALIGN, 8'h00, 6'h00);
    send_item(CmdUnusedLo, 8'hff, 6'h3f);
    send_item(CmdUnusedHi, 8'h00, 6'h00);
    send_item(CMD_READ_BITS, 8'h00, 6'd0);
  endtask

  // fills the ring past capacity, then reads across byte edges
  task automatic test_ring_fill();
    gap_style = 2;
    send_item(CMD_PUSH, 8'hff, 6'h00);
    send_item(CMD_PUSH, 8'h00, 6'h3f);
    repeat (RingBytes - 2) send_item(CMD_PUSH, 8'h77, 6'h00);
    send_item(CMD_PUSH, 8'ha5, 6'h00);
    send_item(CMD_READ_BITS, 8'h00, 6'h3f);
    send_item(CMD_READ_BITS, 8'h00, 6'd3);
    send_item(CMD_ALIGN, 8'h00, 6'h00);
    // groups never terminate before the data runs out
    send_item(CMD_READ_INT, 8'h00, 6'h00);
    wait_reader_idle();
  endtask

  task automatic test_random_open();
    run_random(OpenPhaseItems);
    wait_reader_idle();
  endtask

  // end of stream: ones past the data, integer overflow, push after end
  task automatic test_stream_end();
    int unsigned left;
    gap_style = 1;
    while (ring_fill != 0) begin
      left = bits_buffered();
      send_item(CMD_READ_BITS, 8'h00, 6'((left > MaxReadBits) ? MaxReadBits : left));
    end
    repeat (11) send_item(CMD_PUSH, 8'h77, 6'h00);
    send_item(CMD_MARK_END, 8'h00, 6'h00);
    send_item(CMD_MARK_END, 8'hff, 6'h3f);
    send_item(CMD_READ_INT, 8'h00, 6'h00);
    send_item(CMD_READ_BITS, 8'h00, 6'd8);
    send_item(CMD_READ_INT, 8'h00, 6'h00);
    send_item(CMD_PUSH, 8'h12, 6'h00);
    send_item(CMD_READ_BITS, 8'h00, 6'd12);
    wait_reader_idle();
  endtask

  task automatic test_random_closed();
    run_random(ClosedPhaseItems);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item_in <= '0;
    mismatches = 0;
    items_sent = 0;
    gap_style = 0;
    ring_head = 0;
    ring_fill = 0;
    ring_boff = 0;
    stream_closed = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_reader();
    test_ring_fill();
    test_random_open();
    test_stream_end();
    test_random_closed();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_msb_bit_reader_octal_int OK");
    end else begin
      $display("tb_msb_bit_reader_octal_int NOT OK");
    end
    $finish;
  end

endmodule
